@@ rtl/trps_pkg.sv @@
package trps_pkg;

  localparam int MAX_RUN_DEF = 63;

  localparam int PIX_W   = 24;
  localparam int LUMA_W  = 8;
  localparam int WORD_W  = LUMA_W + PIX_W;
  localparam int SUM_W   = 18;
  localparam int CFG_IDX_W = 2;

  // floor(sum / 1000) is taken as (sum * LUMA_RECIP) >> LUMA_SHIFT. The
  // error of the rounded-up reciprocal stays below 1/1000 for any sum
  // below 256000, so the quotient is exact.
  localparam int LUMA_SHIFT = 28;
  localparam logic [18:0] LUMA_RECIP = 19'd268436;

  localparam logic [7:0] LOW_RESET  = 8'd30;
  localparam logic [7:0] HIGH_RESET = 8'd210;

  localparam logic [CFG_IDX_W-1:0] REG_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DECIDE,
    ST_SHIFT,
    ST_PLACE,
    ST_AFTER,
    ST_FL_RD,
    ST_FL_WR
  } state_t;

  typedef enum logic {
    PH_FLUSH_ONLY,
    PH_PASS
  } tail_t;

endpackage

@@ rtl/trps_ram.sv @@
module trps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 63
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/trps_luma.sv @@
module trps_luma
  import trps_pkg::*;
(
  input  logic              clk,
  input  logic              load,
  input  logic [PIX_W-1:0]  pix,
  output logic [LUMA_W-1:0] luma
);

  logic [SUM_W-1:0] sum;
  logic [SUM_W+19-1:0] prod;

  // Weighted sum is registered when the pixel is accepted; the reciprocal
  // multiply of that sum is registered into luma in the next cycle.
  always_ff @(posedge clk) begin
    if (load) begin
      sum <= SUM_W'(pix[7:0]) * SUM_W'(299) + SUM_W'(pix[15:8]) * SUM_W'(587)
           + SUM_W'(pix[23:16]) * SUM_W'(114);
    end
    luma <= prod[LUMA_SHIFT +: LUMA_W];
  end

  assign prod = sum * LUMA_RECIP;

endmodule

@@ rtl/threshold_run_pixel_sorter.sv @@
// An in-range pixel that causes no flush passes the calc, decide and insertion
// steps; the insertion walk moves one stored entry per cycle.
// A flush handles each item by a memory read, then an output load (held while
// the output stalls). A new pixel is accepted only after the last is done.
// Reset (rst, synchronous) empties the run and restores thresholds 30 and 210;
// the run memory itself is not cleared and needs no clearing pass.
module threshold_run_pixel_sorter
  import trps_pkg::*;
#(
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Pixel input. tdata fields from bit 0: red_in, green_in, blue_in.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [PIX_W-1:0]     s_tdata,
  input  logic                 s_tlast,   // line_end
  // Pixel output. tdata fields from bit 0: red_out, green_out, blue_out.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [PIX_W-1:0]     m_tdata,
  output logic                 m_tlast,   // last_of_burst
  // Threshold write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int AW    = $clog2(MAX_RUN);
  localparam int LEN_W = $clog2(MAX_RUN + 1);
  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(MAX_RUN);

  state_t state, state_next;
  tail_t  tail, tail_next;

  logic [7:0]        low_thr, high_thr;
  logic [PIX_W-1:0]  pix;
  logic              line_end;
  logic [LUMA_W-1:0] luma;
  logic [WORD_W-1:0] word;

  logic [LEN_W-1:0] run_len, run_len_next;
  logic [LEN_W-1:0] idx, idx_next;
  logic [AW-1:0]    pos, pos_next;
  logic             final_flush, final_flush_next;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic             out_free, out_load, out_last_d;
  logic [PIX_W-1:0] out_data_d;
  logic             accept, in_range;

  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign word      = {luma, pix};
  assign in_range  = (luma >= low_thr) && (luma <= high_thr);
  assign out_free  = !m_tvalid || m_tready;

  trps_luma u_luma (
    .clk  (clk),
    .load (accept),
    .pix  (s_tdata),
    .luma (luma)
  );

  // The run is kept sorted in memory: entry 0 has the lowest luma.
  trps_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_RUN)
  ) u_run_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      tail        <= PH_FLUSH_ONLY;
      run_len     <= '0;
      idx         <= '0;
      pos         <= '0;
      final_flush <= 1'b0;
      m_tvalid    <= 1'b0;
      low_thr     <= LOW_RESET;
      high_thr    <= HIGH_RESET;
    end else begin
      state       <= state_next;
      tail        <= tail_next;
      run_len     <= run_len_next;
      idx         <= idx_next;
      pos         <= pos_next;
      final_flush <= final_flush_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid) begin
        if (cfg_index == REG_LOW) begin
          low_thr <= cfg_data;
        end else if (cfg_index == REG_HIGH) begin
          high_thr <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix      <= s_tdata;
      line_end <= s_tlast;
    end
    if (out_load) begin
      m_tdata <= out_data_d;
      m_tlast <= out_last_d;
    end
  end

  // Sequencer: decide, walk the sorted run downward to insert, then flush by
  // reading the memory in address order. The pass-through pixel of an
  // out-of-range item follows its flush (tail == PH_PASS, state ST_PLACE is
  // not used for that; ST_AFTER handles it when the run is empty).
  always_comb begin
    state_next       = state;
    tail_next        = tail;
    run_len_next     = run_len;
    idx_next         = idx;
    pos_next         = pos;
    final_flush_next = final_flush;
    s_tready         = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = pos;
    ram_wdata        = word;
    ram_re           = 1'b0;
    ram_raddr        = pos - AW'(1);
    out_load         = 1'b0;
    out_data_d       = pix;
    out_last_d       = 1'b1;

    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (accept) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        idx_next = '0;
        if (in_range) begin
          tail_next        = PH_FLUSH_ONLY;
          final_flush_next = 1'b1;
          if (run_len == '0) begin
            ram_we       = 1'b1;
            ram_waddr    = '0;
            run_len_next = LEN_W'(1);
            state_next   = ST_AFTER;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = AW'(run_len - LEN_W'(1));
            pos_next   = AW'(run_len);
            state_next = ST_SHIFT;
          end
        end else begin
          tail_next        = PH_PASS;
          final_flush_next = 1'b0;
          state_next       = (run_len == '0) ? ST_AFTER : ST_FL_RD;
        end
      end
      ST_SHIFT: begin
        ram_we = 1'b1;
        if (ram_rdata[WORD_W-1 -: LUMA_W] > luma) begin
          ram_wdata = ram_rdata;
          pos_next  = pos - AW'(1);
          if (pos == AW'(1)) begin
            state_next = ST_PLACE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = pos - AW'(2);
          end
        end else begin
          run_len_next = run_len + LEN_W'(1);
          state_next   = ST_AFTER;
        end
      end
      ST_PLACE: begin
        ram_we       = 1'b1;
        run_len_next = run_len + LEN_W'(1);
        state_next   = ST_AFTER;
      end
      ST_AFTER: begin
        if (tail == PH_PASS) begin
          // Run already empty: send the out-of-range pixel itself.
          if (out_free) begin
            out_load   = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (line_end || run_len == FULL_LEN) begin
          state_next = ST_FL_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_FL_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = idx[AW-1:0];
        state_next = ST_FL_WR;
      end
      ST_FL_WR: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data_d = ram_rdata[PIX_W-1:0];
          out_last_d = final_flush && (idx + LEN_W'(1) == run_len);
          idx_next   = idx + LEN_W'(1);
          if (idx + LEN_W'(1) == run_len) begin
            run_len_next = '0;
            state_next   = (tail == PH_PASS) ? ST_AFTER : ST_IDLE;
          end else begin
            state_next = ST_FL_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // The pass-through pixel after a flush goes through ST_AFTER with an
    // empty run, which the PH_PASS arm above serves.
  end

`ifndef NO_ASSERTIONS
  // The run is never at full length while the sorter is idle.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> run_len < FULL_LEN)
    else $error("run length at rest reached the buffer size");

  // The insertion walk never moves below entry zero.
  a_shift_pos: assert property (@(posedge clk) disable iff (rst)
    state == ST_SHIFT |-> pos != '0)
    else $error("insertion walk at position zero");

  // A finished out-of-range item leaves the run empty.
  a_pass_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_AFTER && tail == PH_PASS) |-> run_len == '0)
    else $error("pass-through with a non-empty run");

  // Each flush read is followed by its output step.
  a_flush_seq: assert property (@(posedge clk) disable iff (rst)
    state == ST_FL_RD |=> state == ST_FL_WR)
    else $error("flush read not followed by output step");
`endif

endmodule

@@ tb/threshold_run_pixel_sorter_test.sv @@
`default_nettype none

// Self-checking bench for the luminance threshold pixel sorter. A directed
// table covers reset thresholds, extreme colors and line ends; a full-buffer
// flush test follows. A random phase of scan lines comes last, under several
// threshold settings, inverted ones included. Each accepted pixel goes through
// a local model of the sorter, and expected outputs queue up for the monitor.
module threshold_run_pixel_sorter_test
  import trps_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_CAP = MAX_RUN_DEF;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  // One row of the directed table. When has_exp is set, the single output that
  // this pixel produces is known by hand and is checked against the predictor.
  typedef struct {
    pixel_t pix;
    bit     has_exp;
    pixel_t exp_pix;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [PIX_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [PIX_W-1:0] m_tdata;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  threshold_run_pixel_sorter dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Local copy of the sorter state: the sorted run and both thresholds.
  logic [31:0] sorted_run[RUN_CAP];
  int          run_count = 0;
  logic [7:0]  low_thr = LOW_RESET;
  logic [7:0]  high_thr = HIGH_RESET;
  pixel_t      pending_pixels[$];
  int          expected_total = 0;
  pixel_t      newest_expected;
  row_t        table_rows[$];
  int          mismatches = 0;
  longint      cycle_count = 0;
  bit          rx_stall_off = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  // The run is ended with an error once the cycle count passes the limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // Appends one expected output to the queue the monitor reads.
  function automatic void expect_pixel(input pixel_t p);
    pending_pixels = {pending_pixels, p};
    expected_total++;
    newest_expected = p;
  endfunction

  function automatic void add_row(input pixel_t pix, input bit has_exp,
                                  input pixel_t exp_pix);
    row_t row;
    row.pix = pix;
    row.has_exp = has_exp;
    row.exp_pix = exp_pix;
    table_rows = {table_rows, row};
  endfunction

  function automatic logic [7:0] luma_of(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    int unsigned sum;
    sum = 299 * r + 587 * g + 114 * b;
    return 8'(sum / 1000);
  endfunction

  // Queues every pixel of the run, ascending luma, and then empties the run.
  function automatic void emit_run(input bit ends_burst);
    pixel_t p;
    for (int i = 0; i < run_count; i++) begin
      p.red = sorted_run[i][23:16];
      p.green = sorted_run[i][15:8];
      p.blue = sorted_run[i][7:0];
      p.last = ends_burst && (i == run_count - 1);
      expect_pixel(p);
    end
    run_count = 0;
  endfunction

  // Works out the outputs that one accepted pixel causes.
  function automatic void sort_pixel(input pixel_t pin);
    logic [7:0] y;
    logic [31:0] word;
    int pos;
    pixel_t p;
    y = luma_of(pin.red, pin.green, pin.blue);
    word = {y, pin.red, pin.green, pin.blue};
    if (y >= low_thr && y <= high_thr) begin
      // A new entry goes behind all entries of equal luma, so ties stay in
      // arrival order.
      pos = run_count;
      while (pos > 0 && sorted_run[pos-1][31:24] > y) begin
        sorted_run[pos] = sorted_run[pos-1];
        pos--;
      end
      sorted_run[pos] = word;
      run_count++;
      if (pin.last || run_count >= RUN_CAP) emit_run(1'b1);
    end else begin
      emit_run(1'b0);
      p = pin;
      p.last = 1'b1;
      expect_pixel(p);
    end
  endfunction

  // Output monitor with a random stall before each item, unless rx_stall_off is set.
  initial begin
    int wait_cycles;
    pixel_t got, want;
    @(negedge rst);
    forever begin
      wait_cycles = rx_stall_off ? 0 : $urandom_range(0, 11);
      if (wait_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast};
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel %h", m_tdata));
      end else begin
        want = pending_pixels.pop_front();
        if (got.red !== want.red)
          report_mismatch($sformatf("red %h, want %h", got.red, want.red));
        if (got.green !== want.green)
          report_mismatch($sformatf("green %h, want %h", got.green, want.green));
        if (got.blue !== want.blue)
          report_mismatch($sformatf("blue %h, want %h", got.blue, want.blue));
        if (got.last !== want.last)
          report_mismatch($sformatf("tlast %b, want %b", got.last, want.last));
      end
    end
  end

  // Sends one pixel after a random gap (none when no_gap is set) and feeds the predictor on acceptance.
  task automatic send_pixel(input pixel_t p, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {p.blue, p.green, p.red};
    s_tlast <= p.last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sort_pixel(p);
  endtask

  // Waits until every expected pixel has arrived, then lets the block settle.
  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (RUN_CAP + 10) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_LOW) low_thr = val;
    else if (idx == REG_HIGH) high_thr = val;
  endtask

  function automatic pixel_t mk(input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b, input logic l);
    pixel_t p;
    p.red = r; p.green = g; p.blue = b; p.last = l;
    return p;
  endfunction

  // A random pixel: mostly mid-range channel values that often land in range so
  // that runs grow, the rest anywhere in the color cube.
  function automatic pixel_t random_pixel(input int line_len, input int pos);
    pixel_t p;
    if ($urandom_range(0, 3) != 0) begin
      p.red = 8'($urandom_range(40, 200));
      p.green = 8'($urandom_range(40, 200));
      p.blue = 8'($urandom_range(40, 200));
    end else begin
      p.red = 8'($urandom);
      p.green = 8'($urandom);
      p.blue = 8'($urandom);
    end
    p.last = (pos == line_len - 1) || ($urandom_range(0, 40) == 0);
    return p;
  endfunction

  // Sends a table row whose single output is known, and checks the predictor
  // agrees before the monitor compares it with the block.
  task automatic sort_pixel_check(input row_t row);
    int before_cnt;
    before_cnt = expected_total;
    send_pixel(row.pix, 1'b0);
    if (expected_total != before_cnt + 1 || newest_expected != row.exp_pix)
      report_mismatch("directed row does not give its listed pixel");
  endtask

  initial begin
    int sent;
    int line_len;
    logic [7:0] lo_set[5] = '{8'd0, 8'd0, 8'd100, 8'd200, 8'd30};
    logic [7:0] hi_set[5] = '{8'd255, 8'd128, 8'd180, 8'd50, 8'd210};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows under the reset thresholds 30 and 210.
    // Black is below the low threshold and passes straight through.
    add_row(mk(8'h00, 8'h00, 8'h00, 1'b0), 1'b1, mk(8'd0, 8'd0, 8'd0, 1'b1));
    // White is above the high threshold.
    add_row(mk(8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b1, mk(8'd255, 8'd255, 8'd255, 1'b1));
    // A single-pixel run closed by line end comes back alone.
    add_row(mk(8'd100, 8'd100, 8'd100, 1'b1), 1'b1, mk(8'd100, 8'd100, 8'd100, 1'b1));
    // A run of mixed luma with a tie, flushed by an out-of-range pixel.
    add_row(mk(8'd150, 8'd150, 8'd150, 1'b0), 1'b0, '0);
    add_row(mk(8'd60, 8'd60, 8'd60, 1'b0), 1'b0, '0);
    add_row(mk(8'd150, 8'd150, 8'd150, 1'b0), 1'b0, '0);
    add_row(mk(8'd255, 8'd0, 8'd0, 1'b0), 1'b0, '0);
    add_row(mk(8'd0, 8'd255, 8'd0, 1'b0), 1'b0, '0);
    add_row(mk(8'd0, 8'd0, 8'd255, 1'b0), 1'b0, '0);
    // Line end on an out-of-range pixel after a run.
    add_row(mk(8'd90, 8'd80, 8'd70, 1'b0), 1'b0, '0);
    add_row(mk(8'd5, 8'd5, 8'd5, 1'b1), 1'b0, '0);
    // Exact threshold boundaries: luma 30 and 210 are in range.
    add_row(mk(8'd30, 8'd30, 8'd30, 1'b0), 1'b0, '0);
    add_row(mk(8'd210, 8'd210, 8'd210, 1'b0), 1'b0, '0);
    add_row(mk(8'd29, 8'd29, 8'd29, 1'b0), 1'b0, '0);
    add_row(mk(8'd211, 8'd211, 8'd211, 1'b1), 1'b0, '0);
    add_row(mk(8'hAA, 8'h55, 8'hAA, 1'b1), 1'b0, '0);
    add_row(mk(8'h55, 8'hAA, 8'h55, 1'b1), 1'b0, '0);

    foreach (table_rows[i]) begin
      if (table_rows[i].has_exp) begin
        sort_pixel_check(table_rows[i]);
      end else begin
        send_pixel(table_rows[i].pix, 1'b0);
      end
    end
    drain_outputs();

    // A full buffer flushes on its own; descending luma walks the whole run.
    for (int i = 0; i < RUN_CAP + 2; i++) begin
      send_pixel(mk(8'(200 - 2 * (i % 80)), 8'(200 - 2 * (i % 80)),
                    8'(200 - 2 * (i % 80)), 1'b0), i > 20 && i < 40);
    end
    send_pixel(mk(8'd0, 8'd0, 8'd0, 1'b1), 1'b0);
    drain_outputs();

    // Random scan lines under each threshold setting, the extremes included.
    sent = 0;
    for (int s = 0; s < 5; s++) begin
      write_threshold(REG_LOW, lo_set[s]);
      write_threshold(REG_HIGH, hi_set[s]);
      // An unused register index must change nothing.
      if (s == 2) write_threshold(REG_UNUSED, 8'd7);
      rx_stall_off = (s == 3);
      while (sent < 64 * (s + 1)) begin
        line_len = $urandom_range(1, 30);
        for (int k = 0; k < line_len; k++) begin
          send_pixel(random_pixel(line_len, k), s == 1 && $urandom_range(0, 1) == 1);
          sent++;
        end
        // Once in a while the sender holds off until the output is empty.
        if ($urandom_range(0, 5) == 0) begin
          s_tvalid <= 1'b0;
          @(posedge clk);
          while (pending_pixels.size() != 0) @(posedge clk);
        end
      end
      send_pixel(mk(8'd0, 8'd0, 8'd0, 1'b1), 1'b0);
      drain_outputs();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
